// File: rtl/vebdq_pkg.sv
// Shared types, constants and helpers of the voxel energy box downsampler.
`timescale 1ns / 1ps
package vebdq_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SRC_SIDE = 3'd0;
  localparam logic [2:0] REG_PRV_SIDE = 3'd1;
  localparam logic [2:0] REG_GAIN_TP  = 3'd2;
  localparam logic [2:0] REG_GAIN_PE  = 3'd3;
  localparam logic [2:0] REG_GAIN_TE  = 3'd4;

  // Fraction bits of mean * gain per channel
  localparam int FRAC_TP = 60;
  localparam int FRAC_EN = 48;

  localparam int CELL_W = 18;
  localparam int QNT_W  = 8;

  // Per-voxel channel values and box bookkeeping, front to back
  typedef struct packed {
    logic [47:0]       tp;
    logic [33:0]       pe;
    logic [33:0]       te;
    logic [CELL_W-1:0] cidx;
    logic              close;
    logic              last;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // Magnitude of a signed Q4.12 component; -32768 gives 32768
  function automatic logic [15:0] mag16(input logic [15:0] x);
    return x[15] ? 16'(~x + 16'd1) : x;
  endfunction

endpackage

// File: rtl/vebdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vebdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/vebdq_front.sv
// Front end: accepts voxels, tracks box edges, forms the three channels.
`timescale 1ns / 1ps
module vebdq_front #(
  parameter int SRC_W  = 11,
  parameter int DST_W  = 7,
  parameter int ADDR_W = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic [SRC_W-1:0]              s_eff,
  input  logic [DST_W-1:0]              d_eff,
  input  logic                          acc,
  output logic                          ready,
  input  logic [15:0]                   phi_a,
  input  logic [15:0]                   phi_b,
  input  logic [15:0]                   phi_c,
  input  logic [15:0]                   theta_a,
  input  logic [15:0]                   theta_b,
  input  logic [15:0]                   theta_c,
  output logic                          q_push,
  input  logic                          q_full,
  output vebdq_pkg::item_t              q_item,
  output logic [ADDR_W-1:0]             q_addr,
  output logic [SRC_W-1:0]              q_li,
  output logic [SRC_W-1:0]              q_lj,
  output logic [SRC_W-1:0]              q_lk
);

  localparam int DV_CW = $clog2(SRC_W + 1);

  typedef enum logic [6:0] {
    F_START = 7'b0000001,
    F_DIV   = 7'b0000010,
    F_SEED  = 7'b0000100,
    F_IDLE  = 7'b0001000,
    F_MUL1  = 7'b0010000,
    F_MUL2  = 7'b0100000,
    F_PUSH  = 7'b1000000
  } fst_t;

  fst_t st_r;

  // S / D by restoring division at (re)start
  logic [SRC_W-1:0] dv_q_r;
  logic [DST_W-1:0] dv_rem_r;
  logic [DV_CW-1:0] dv_cnt_r;
  logic [DST_W:0]   dv_trial;
  logic             dv_bit;
  logic [SRC_W-1:0] q_r;
  logic [DST_W-1:0] r_r;

  // Axis trackers: position, start/end edge, edge remainder, box index
  logic [SRC_W-1:0] pi_r, pj_r, pk_r, si_r, sj_r, sk_r, ei_r, ej_r, ek_r;
  logic [DST_W-1:0] ri_r, rj_r, rk_r, di_r, dj_r, dk_r;
  logic [SRC_W-1:0] pi_nxt, pj_nxt, pk_nxt, si_nxt, sj_nxt, sk_nxt;
  logic [SRC_W-1:0] ei_nxt, ej_nxt, ek_nxt;
  logic [DST_W-1:0] ri_nxt, rj_nxt, rk_nxt, di_nxt, dj_nxt, dk_nxt;
  logic [ADDR_W-1:0] row_r, row_nxt;
  logic [17:0]      plane_r, plane_nxt, dd_r;
  logic [SRC_W:0]   i1, j1, k1;

  logic [15:0]      mg_r [6];
  logic [31:0]      pab_r;
  logic [31:0]      sq_r [6];
  logic [15:0]      pc_r;
  vebdq_pkg::item_t it_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SRC_W-1:0] li_r, lj_r, lk_r;

  function automatic logic [SRC_W+DST_W-1:0] edge_step(
    input logic [SRC_W-1:0] e,
    input logic [DST_W-1:0] rm
  );
    logic [DST_W:0] t;
    t = {1'b0, rm} + {1'b0, r_r};
    if (t >= {1'b0, d_eff}) begin
      return {SRC_W'({1'b0, e} + {1'b0, q_r} + 1'b1), DST_W'(t - {1'b0, d_eff})};
    end
    return {SRC_W'({1'b0, e} + {1'b0, q_r}), DST_W'(t)};
  endfunction

  assign dv_trial = {dv_rem_r, dv_q_r[SRC_W-1]};
  assign dv_bit   = (dv_trial >= {1'b0, d_eff});

  assign i1 = {1'b0, pi_r} + 1'b1;
  assign j1 = {1'b0, pj_r} + 1'b1;
  assign k1 = {1'b0, pk_r} + 1'b1;

  // Raster advance of the trackers for one voxel
  always_comb begin
    pi_nxt = pi_r; pj_nxt = pj_r; pk_nxt = pk_r;
    si_nxt = si_r; sj_nxt = sj_r; sk_nxt = sk_r;
    ei_nxt = ei_r; ej_nxt = ej_r; ek_nxt = ek_r;
    ri_nxt = ri_r; rj_nxt = rj_r; rk_nxt = rk_r;
    di_nxt = di_r; dj_nxt = dj_r; dk_nxt = dk_r;
    row_nxt = row_r; plane_nxt = plane_r;
    if (k1 < {1'b0, s_eff}) begin
      pk_nxt = SRC_W'(k1);
      if (k1 == {1'b0, ek_r}) begin
        dk_nxt = DST_W'({1'b0, dk_r} + 1'b1);
        sk_nxt = ek_r;
        {ek_nxt, rk_nxt} = edge_step(ek_r, rk_r);
      end
    end else begin
      pk_nxt = '0; dk_nxt = '0; sk_nxt = '0; ek_nxt = q_r; rk_nxt = r_r;
      if (j1 < {1'b0, s_eff}) begin
        pj_nxt = SRC_W'(j1);
        if (j1 == {1'b0, ej_r}) begin
          dj_nxt = DST_W'({1'b0, dj_r} + 1'b1);
          sj_nxt = ej_r;
          {ej_nxt, rj_nxt} = edge_step(ej_r, rj_r);
          row_nxt = ADDR_W'(32'(row_r) + 32'(d_eff));
        end
      end else begin
        pj_nxt = '0; dj_nxt = '0; sj_nxt = '0; ej_nxt = q_r; rj_nxt = r_r;
        row_nxt = '0;
        if (i1 < {1'b0, s_eff}) begin
          pi_nxt = SRC_W'(i1);
          if (i1 == {1'b0, ei_r}) begin
            di_nxt = DST_W'({1'b0, di_r} + 1'b1);
            si_nxt = ei_r;
            {ei_nxt, ri_nxt} = edge_step(ei_r, ri_r);
            plane_nxt = 18'(plane_r + dd_r);
          end
        end else begin
          pi_nxt = '0; di_nxt = '0; si_nxt = '0; ei_nxt = q_r; ri_nxt = r_r;
          plane_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_START;
    end else if (restart) begin
      st_r <= F_START;
    end else begin
      case (st_r)
        F_START: begin
          dv_q_r   <= s_eff;
          dv_rem_r <= '0;
          dv_cnt_r <= DV_CW'(SRC_W);
          st_r     <= F_DIV;
        end
        F_DIV: begin
          dv_q_r   <= SRC_W'({dv_q_r, dv_bit});
          dv_rem_r <= dv_bit ? DST_W'(dv_trial - {1'b0, d_eff}) : DST_W'(dv_trial);
          dv_cnt_r <= dv_cnt_r - 1'b1;
          if (dv_cnt_r == DV_CW'(1)) begin
            st_r <= F_SEED;
          end
        end
        F_SEED: begin
          q_r <= dv_q_r; r_r <= dv_rem_r;
          pi_r <= '0; pj_r <= '0; pk_r <= '0;
          si_r <= '0; sj_r <= '0; sk_r <= '0;
          ei_r <= dv_q_r; ej_r <= dv_q_r; ek_r <= dv_q_r;
          ri_r <= dv_rem_r; rj_r <= dv_rem_r; rk_r <= dv_rem_r;
          di_r <= '0; dj_r <= '0; dk_r <= '0;
          row_r <= '0; plane_r <= '0;
          dd_r <= 18'(d_eff) * 18'(d_eff);
          st_r <= F_IDLE;
        end
        F_IDLE: begin
          if (acc) begin
            mg_r[0] <= vebdq_pkg::mag16(phi_a);
            mg_r[1] <= vebdq_pkg::mag16(phi_b);
            mg_r[2] <= vebdq_pkg::mag16(phi_c);
            mg_r[3] <= vebdq_pkg::mag16(theta_a);
            mg_r[4] <= vebdq_pkg::mag16(theta_b);
            mg_r[5] <= vebdq_pkg::mag16(theta_c);
            it_r.close <= (i1 == {1'b0, ei_r}) && (j1 == {1'b0, ej_r}) &&
                          (k1 == {1'b0, ek_r});
            it_r.last  <= ({1'b0, di_r} + 1'b1 == {1'b0, d_eff}) &&
                          ({1'b0, dj_r} + 1'b1 == {1'b0, d_eff}) &&
                          ({1'b0, dk_r} + 1'b1 == {1'b0, d_eff});
            it_r.cidx  <= 18'(plane_r + 18'(row_r) + 18'(dk_r));
            addr_r     <= ADDR_W'(32'(row_r) + 32'(dk_r));
            li_r <= SRC_W'(ei_r - si_r);
            lj_r <= SRC_W'(ej_r - sj_r);
            lk_r <= SRC_W'(ek_r - sk_r);
            pi_r <= pi_nxt; pj_r <= pj_nxt; pk_r <= pk_nxt;
            si_r <= si_nxt; sj_r <= sj_nxt; sk_r <= sk_nxt;
            ei_r <= ei_nxt; ej_r <= ej_nxt; ek_r <= ek_nxt;
            ri_r <= ri_nxt; rj_r <= rj_nxt; rk_r <= rk_nxt;
            di_r <= di_nxt; dj_r <= dj_nxt; dk_r <= dk_nxt;
            row_r <= row_nxt; plane_r <= plane_nxt;
            st_r <= F_MUL1;
          end
        end
        F_MUL1: begin
          pab_r <= mg_r[0] * mg_r[1];
          pc_r  <= mg_r[2];
          for (int n = 0; n < 6; n++) begin
            sq_r[n] <= mg_r[n] * mg_r[n];
          end
          st_r <= F_MUL2;
        end
        F_MUL2: begin
          it_r.tp <= pab_r * pc_r;
          it_r.pe <= 34'(sq_r[0]) + 34'(sq_r[1]) + 34'(sq_r[2]);
          it_r.te <= 34'(sq_r[3]) + 34'(sq_r[4]) + 34'(sq_r[5]);
          st_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            st_r <= F_IDLE;
          end
        end
        default: st_r <= F_START;
      endcase
    end
  end

  assign ready  = (st_r == F_IDLE);
  assign q_push = (st_r == F_PUSH) && !q_full;
  assign q_item = it_r;
  assign q_addr = addr_r;
  assign q_li   = li_r;
  assign q_lj   = lj_r;
  assign q_lk   = lk_r;

endmodule

// File: rtl/vebdq_back.sv
// Back end: box accumulators, mean division, gain scaling and result register.
`timescale 1ns / 1ps
module vebdq_back #(
  parameter int SRC_W  = 11,
  parameter int ADDR_W = 12,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     restart,
  input  logic [31:0]              gain_tp,
  input  logic [31:0]              gain_pe,
  input  logic [31:0]              gain_te,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  vebdq_pkg::item_t         q_item,
  input  logic [ADDR_W-1:0]        q_addr,
  input  logic [SRC_W-1:0]         q_li,
  input  logic [SRC_W-1:0]         q_lj,
  input  logic [SRC_W-1:0]         q_lk,
  output vebdq_pkg::back_stat_t    stat,
  output logic                     empty,
  input  logic                     pop,
  output logic [17:0]              cell_index,
  output logic [7:0]               triple_product_q,
  output logic [7:0]               phi_energy_q,
  output logic [7:0]               theta_energy_q,
  output logic                     frame_done
);

  localparam int CNT_W = 3 * SRC_W;

  typedef enum logic [8:0] {
    B_CLEAR = 9'b000000001,
    B_IDLE  = 9'b000000010,
    B_ADD   = 9'b000000100,
    B_CNT1  = 9'b000001000,
    B_CNT2  = 9'b000010000,
    B_DIV   = 9'b000100000,
    B_QMUL  = 9'b001000000,
    B_QSUM  = 9'b010000000,
    B_OUT   = 9'b100000000
  } bst_t;

  bst_t st_r;
  logic [ADDR_W-1:0]  clr_r, addr_r;
  vebdq_pkg::item_t   it_r;
  logic [SRC_W-1:0]   li_r, lj_r, lk_r;
  logic [2*SRC_W-1:0] cij_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   rem_r [3];
  logic [63:0]        qt_r [3];
  logic [5:0]         dcnt_r;
  logic [63:0]        plo_r [3];
  logic [63:0]        phi_r [3];
  logic [7:0]         qres_r [3];
  logic [31:0]        gain [3];

  logic               out_v_r;
  logic [17:0]        o_cell_r;
  logic [7:0]         o_tp_r, o_pe_r, o_te_r;
  logic               o_last_r;

  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [191:0]       wdata, rdata;
  logic [63:0]        sum_nxt [3];
  logic [CNT_W:0]     trial [3];
  logic               qbit [3];

  function automatic logic [63:0] sat64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // round half up of (hi:lo) >> frac, clamped to 255
  function automatic logic [7:0] quant(input logic [63:0] lo, input logic [63:0] hi,
                                       input int frac);
    logic [96:0] tot;
    logic [96:0] hv;
    tot = {1'b0, hi, 32'd0} + {33'd0, lo} + (97'd1 << (frac - 1));
    hv  = tot >> frac;
    return (|hv[96:8]) ? 8'hFF : hv[7:0];
  endfunction

  vebdq_ram #(.WIDTH(192), .DEPTH(DEPTH)) u_acc (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign gain[0] = gain_tp;
  assign gain[1] = gain_pe;
  assign gain[2] = gain_te;

  assign sum_nxt[0] = sat64(rdata[191:128], 64'(it_r.tp));
  assign sum_nxt[1] = sat64(rdata[127:64],  64'(it_r.pe));
  assign sum_nxt[2] = sat64(rdata[63:0],    64'(it_r.te));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_r[c], qt_r[c][63]};
      qbit[c]  = (trial[c] >= {1'b0, cnt_r});
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = '0;
    raddr = q_addr;
    case (st_r)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
      end
      B_ADD: begin
        we    = 1'b1;
        wdata = it_r.close ? '0 : {sum_nxt[0], sum_nxt[1], sum_nxt[2]};
      end
      default: ;
    endcase
  end

  assign q_pop = (st_r == B_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_CLEAR;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
      if (restart) begin
        st_r  <= B_CLEAR;
        clr_r <= '0;
      end else begin
        case (st_r)
          B_CLEAR: begin
            clr_r <= clr_r + 1'b1;
            if (clr_r == ADDR_W'(DEPTH - 1)) begin
              st_r <= B_IDLE;
            end
          end
          B_IDLE: begin
            if (q_valid) begin
              it_r   <= q_item;
              addr_r <= q_addr;
              li_r <= q_li; lj_r <= q_lj; lk_r <= q_lk;
              st_r   <= B_ADD;
            end
          end
          B_ADD: begin
            for (int c = 0; c < 3; c++) begin
              qt_r[c] <= sum_nxt[c];
            end
            st_r <= it_r.close ? B_CNT1 : B_IDLE;
          end
          B_CNT1: begin
            cij_r <= li_r * lj_r;
            st_r  <= B_CNT2;
          end
          B_CNT2: begin
            cnt_r  <= cij_r * lk_r;
            for (int c = 0; c < 3; c++) begin
              rem_r[c] <= '0;
            end
            dcnt_r <= 6'd63;
            st_r   <= B_DIV;
          end
          B_DIV: begin
            for (int c = 0; c < 3; c++) begin
              rem_r[c] <= qbit[c] ? CNT_W'(trial[c] - {1'b0, cnt_r}) : CNT_W'(trial[c]);
              qt_r[c]  <= {qt_r[c][62:0], qbit[c]};
            end
            dcnt_r <= dcnt_r - 1'b1;
            if (dcnt_r == 6'd0) begin
              st_r <= B_QMUL;
            end
          end
          B_QMUL: begin
            for (int c = 0; c < 3; c++) begin
              plo_r[c] <= qt_r[c][31:0] * gain[c];
              phi_r[c] <= qt_r[c][63:32] * gain[c];
            end
            st_r <= B_QSUM;
          end
          B_QSUM: begin
            qres_r[0] <= quant(plo_r[0], phi_r[0], vebdq_pkg::FRAC_TP);
            qres_r[1] <= quant(plo_r[1], phi_r[1], vebdq_pkg::FRAC_EN);
            qres_r[2] <= quant(plo_r[2], phi_r[2], vebdq_pkg::FRAC_EN);
            st_r <= B_OUT;
          end
          B_OUT: begin
            if (!out_v_r) begin
              out_v_r  <= 1'b1;
              o_cell_r <= it_r.cidx;
              o_tp_r   <= qres_r[0];
              o_pe_r   <= qres_r[1];
              o_te_r   <= qres_r[2];
              o_last_r <= it_r.last;
              st_r     <= B_IDLE;
            end
          end
          default: st_r <= B_CLEAR;
        endcase
      end
    end
  end

  assign stat.clearing   = (st_r == B_CLEAR);
  assign empty           = !out_v_r;
  assign cell_index      = o_cell_r;
  assign triple_product_q = o_tp_r;
  assign phi_energy_q    = o_pe_r;
  assign theta_energy_q  = o_te_r;
  assign frame_done      = o_last_r;

endmodule

// File: rtl/voxel_energy_box_downsample_quantize_unit.sv
// Top level: config registers, front end, item queue and back end.
`timescale 1ns / 1ps
// An item reaches the queue after the front end's two multiply stages; the back end
//   reads and adds each item, and one that closes a box also passes count, 64-step
//   mean division, gain multiply and rounding before the result is shown.
// The front end takes a new voxel only once it has pushed the last one to the queue;
//   box-closing items are bounded by the back end's serial divider.
// Reset (rst_n low, synchronous) and any size write start a clearing pass over all
//   MAX_PREVIEW_SIDE^2 accumulator rows, one row a cycle, with full held high.
module voxel_energy_box_downsample_quantize_unit #(
  parameter int MAX_PREVIEW_SIDE = 64,
  parameter int MAX_SOURCE_SIDE  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_phi_a,
  input  logic [15:0] in_phi_b,
  input  logic [15:0] in_phi_c,
  input  logic [15:0] in_theta_a,
  input  logic [15:0] in_theta_b,
  input  logic [15:0] in_theta_c,
  output logic        empty,
  input  logic        pop,
  output logic [17:0] out_cell_index,
  output logic [7:0]  out_triple_product_q,
  output logic [7:0]  out_phi_energy_q,
  output logic [7:0]  out_theta_energy_q,
  output logic        out_frame_done
);

  localparam int SRC_W  = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int DST_W  = $clog2(MAX_PREVIEW_SIDE + 1);
  localparam int DEPTH  = MAX_PREVIEW_SIDE * MAX_PREVIEW_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // queue entry between front and back
  typedef struct packed {
    vebdq_pkg::item_t  it;
    logic [ADDR_W-1:0] addr;
    logic [SRC_W-1:0]  li;
    logic [SRC_W-1:0]  lj;
    logic [SRC_W-1:0]  lk;
  } qent_t;

  logic [10:0] src_side_r;
  logic [6:0]  prv_side_r;
  logic [31:0] gain_tp_r, gain_pe_r, gain_te_r;
  logic        restart;

  logic [SRC_W-1:0] s_eff;
  logic [DST_W-1:0] d_eff;
  logic [31:0]      s_sat, d_sat;

  logic              f_ready, f_push, acc;
  vebdq_pkg::item_t  f_item;
  logic [ADDR_W-1:0] f_addr;
  logic [SRC_W-1:0]  f_li, f_lj, f_lk;

  qent_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       q_full, q_valid, b_pop;
  qent_t      head;

  vebdq_pkg::back_stat_t b_stat;

  // size writes restart the volume
  assign restart = cfg_we && ((cfg_index == vebdq_pkg::REG_SRC_SIDE) ||
                              (cfg_index == vebdq_pkg::REG_PRV_SIDE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_side_r <= 11'd64;
      prv_side_r <= 7'd64;
      gain_tp_r  <= '0;
      gain_pe_r  <= '0;
      gain_te_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vebdq_pkg::REG_SRC_SIDE: src_side_r <= cfg_wdata[10:0];
        vebdq_pkg::REG_PRV_SIDE: prv_side_r <= cfg_wdata[6:0];
        vebdq_pkg::REG_GAIN_TP:  gain_tp_r  <= cfg_wdata;
        vebdq_pkg::REG_GAIN_PE:  gain_pe_r  <= cfg_wdata;
        vebdq_pkg::REG_GAIN_TE:  gain_te_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective sizes: S in 1..MAX_SOURCE_SIDE, D in 1..MAX_PREVIEW_SIDE and <= S
  always_comb begin
    s_sat = 32'(src_side_r);
    if (s_sat < 32'd1) s_sat = 32'd1;
    if (s_sat > 32'(MAX_SOURCE_SIDE)) s_sat = 32'(MAX_SOURCE_SIDE);
    d_sat = 32'(prv_side_r);
    if (d_sat < 32'd1) d_sat = 32'd1;
    if (d_sat > 32'(MAX_PREVIEW_SIDE)) d_sat = 32'(MAX_PREVIEW_SIDE);
    if (d_sat > s_sat) d_sat = s_sat;
  end

  assign s_eff = SRC_W'(s_sat);
  assign d_eff = DST_W'(d_sat);

  assign full = !f_ready || b_stat.clearing;
  assign acc  = push && !full;

  vebdq_front #(.SRC_W(SRC_W), .DST_W(DST_W), .ADDR_W(ADDR_W)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .s_eff   (s_eff),
    .d_eff   (d_eff),
    .acc     (acc),
    .ready   (f_ready),
    .phi_a   (in_phi_a),
    .phi_b   (in_phi_b),
    .phi_c   (in_phi_c),
    .theta_a (in_theta_a),
    .theta_b (in_theta_b),
    .theta_c (in_theta_c),
    .q_push  (f_push),
    .q_full  (q_full),
    .q_item  (f_item),
    .q_addr  (f_addr),
    .q_li    (f_li),
    .q_lj    (f_lj),
    .q_lk    (f_lk)
  );

  // two-entry queue, front to back
  assign q_full  = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign head    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (f_push) begin
        ent_r[wp_r] <= '{it: f_item, addr: f_addr, li: f_li, lj: f_lj, lk: f_lk};
        wp_r <= !wp_r;
      end
      if (b_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, f_push} - {1'b0, b_pop};
    end
  end

  vebdq_back #(.SRC_W(SRC_W), .ADDR_W(ADDR_W), .DEPTH(DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .restart          (restart),
    .gain_tp          (gain_tp_r),
    .gain_pe          (gain_pe_r),
    .gain_te          (gain_te_r),
    .q_valid          (q_valid),
    .q_pop            (b_pop),
    .q_item           (head.it),
    .q_addr           (head.addr),
    .q_li             (head.li),
    .q_lj             (head.lj),
    .q_lk             (head.lk),
    .stat             (b_stat),
    .empty            (empty),
    .pop              (pop),
    .cell_index       (out_cell_index),
    .triple_product_q (out_triple_product_q),
    .phi_energy_q     (out_phi_energy_q),
    .theta_energy_q   (out_theta_energy_q),
    .frame_done       (out_frame_done)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("item queue over capacity");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.clearing |-> full)
    else $error("input open during clearing pass");

  a_restart_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> full)
    else $error("input open right after size write");

endmodule

// File: tb/tb_voxel_energy_box_downsample_quantize_unit.sv
// Testbench of the voxel energy box downsampler: queued driver, checking monitor, predictor.
`timescale 1ns / 1ps
module tb_voxel_energy_box_downsample_quantize_unit;

  localparam int MAX_PRV    = 64;
  localparam int MAX_SRC    = 1024;
  localparam int ROWS       = MAX_PRV * MAX_PRV;
  localparam int DRAIN_WAIT = 200;      // covers the block's latency from item to result
  localparam int CYCLE_CAP  = 2000000;

  // One source voxel: six signed Q4.12 components
  typedef struct packed {
    logic [15:0] phi_a, phi_b, phi_c, theta_a, theta_b, theta_c;
  } voxel_t;

  // One finished destination cell
  typedef struct packed {
    logic [17:0] cidx;
    logic [7:0]  tp_q, pe_q, te_q;
    logic        done;
  } cell_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  voxel_t      drv_vox = '0;
  logic        empty;
  logic        pop = 1'b0;
  cell_t       got;

  voxel_energy_box_downsample_quantize_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .push(push), .full(full),
    .in_phi_a(drv_vox.phi_a), .in_phi_b(drv_vox.phi_b), .in_phi_c(drv_vox.phi_c),
    .in_theta_a(drv_vox.theta_a), .in_theta_b(drv_vox.theta_b),
    .in_theta_c(drv_vox.theta_c),
    .empty(empty), .pop(pop),
    .out_cell_index(got.cidx), .out_triple_product_q(got.tp_q),
    .out_phi_energy_q(got.pe_q), .out_theta_energy_q(got.te_q),
    .out_frame_done(got.done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: own copy of registers, accumulators and positions
  // ---------------------------------------------------------------------
  logic [10:0] p_src;
  logic [6:0]  p_prv;
  logic [31:0] p_gain_tp, p_gain_pe, p_gain_te;
  logic [63:0] acc_tp [ROWS];
  logic [63:0] acc_pe [ROWS];
  logic [63:0] acc_te [ROWS];
  int unsigned vi, vj, vk;          // source voxel position
  int unsigned ci, cj, ck;          // destination cell position
  int unsigned si, ei, sj, ej, sk, ek;

  voxel_t pending_voxels[$];
  cell_t  expected_cells[$];

  int unsigned errors = 0;
  int unsigned cells_checked = 0;
  int unsigned voxels_sent = 0;
  int unsigned frames_seen = 0;
  int unsigned cycles = 0;

  int sender_idle = 0;              // percent of cycles the sender holds back
  int recv_stall  = 0;              // percent of cycles the receiver stalls
  int unsigned accepts = 0;         // bumped at each accepted item
  int unsigned accepts_seen = 0;
  int unsigned holdoff_req = 0;     // toggled count: a new long hold-off request
  int unsigned holdoff_ack = 0;
  int unsigned holdoff_left = 0;

  function automatic int unsigned src_eff();
    int unsigned s;
    s = p_src;
    if (s < 1) s = 1;
    if (s > MAX_SRC) s = MAX_SRC;
    return s;
  endfunction

  function automatic int unsigned prv_eff();
    int unsigned d;
    d = p_prv;
    if (d < 1) d = 1;
    if (d > MAX_PRV) d = MAX_PRV;
    if (d > src_eff()) d = src_eff();
    return d;
  endfunction

  function automatic int unsigned box_edge(int unsigned d);
    longint unsigned p;
    p = longint'(d) * src_eff();
    return int'(p / prv_eff());
  endfunction

  function automatic logic [63:0] magnitude(logic [15:0] x);
    logic [16:0] m;
    m = x[15] ? (17'h10000 - {1'b0, x}) : {1'b0, x};
    return 64'(m);
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[64] ? '1 : r[63:0];
  endfunction

  // mean * gain rounded half up at frac bits, clamped to 255
  function automatic logic [7:0] to_u8(logic [63:0] sum, logic [63:0] cnt,
                                       logic [31:0] gain, int frac);
    logic [63:0]  mean;
    logic [127:0] p;
    mean = sum / cnt;
    p = 128'(mean) * 128'(gain);
    p = (p + (128'd1 << (frac - 1))) >> frac;
    return (p > 128'd255) ? 8'd255 : p[7:0];
  endfunction

  task automatic restart_volume();
    for (int n = 0; n < ROWS; n++) begin
      acc_tp[n] = '0; acc_pe[n] = '0; acc_te[n] = '0;
    end
    vi = 0; vj = 0; vk = 0; ci = 0; cj = 0; ck = 0;
    si = 0; sj = 0; sk = 0;
    ei = box_edge(1); ej = ei; ek = ei;
  endtask

  task automatic apply_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      vebdq_pkg::REG_SRC_SIDE: begin p_src = val[10:0]; restart_volume(); end
      vebdq_pkg::REG_PRV_SIDE: begin p_prv = val[6:0]; restart_volume(); end
      vebdq_pkg::REG_GAIN_TP:  p_gain_tp = val;
      vebdq_pkg::REG_GAIN_PE:  p_gain_pe = val;
      vebdq_pkg::REG_GAIN_TE:  p_gain_te = val;
      default: ;
    endcase
  endtask

  // Accumulate one voxel, emit a cell when it closes its box, advance
  task automatic accumulate_voxel(voxel_t v);
    int unsigned s, d, row;
    logic [63:0] pa, pb, pc, ta, tb, tc, cnt;
    cell_t c;
    s = src_eff();
    d = prv_eff();
    pa = magnitude(v.phi_a); pb = magnitude(v.phi_b); pc = magnitude(v.phi_c);
    ta = magnitude(v.theta_a); tb = magnitude(v.theta_b); tc = magnitude(v.theta_c);
    row = (cj * d + ck) % ROWS;
    acc_tp[row] = sat_sum(acc_tp[row], pa * pb * pc);
    acc_pe[row] = sat_sum(acc_pe[row], pa * pa + pb * pb + pc * pc);
    acc_te[row] = sat_sum(acc_te[row], ta * ta + tb * tb + tc * tc);
    if (vi + 1 == ei && vj + 1 == ej && vk + 1 == ek) begin
      cnt = 64'(ei - si) * 64'(ej - sj) * 64'(ek - sk);
      if (cnt == 0) cnt = 1;
      c.cidx = 18'(longint'(ci) * d * d + cj * d + ck);
      c.tp_q = to_u8(acc_tp[row], cnt, p_gain_tp, vebdq_pkg::FRAC_TP);
      c.pe_q = to_u8(acc_pe[row], cnt, p_gain_pe, vebdq_pkg::FRAC_EN);
      c.te_q = to_u8(acc_te[row], cnt, p_gain_te, vebdq_pkg::FRAC_EN);
      c.done = (ci + 1 == d && cj + 1 == d && ck + 1 == d);
      expected_cells.push_back(c);
      acc_tp[row] = '0; acc_pe[row] = '0; acc_te[row] = '0;
    end
    // k fastest, then j, then i; wrap to a new volume at the end
    vk++;
    if (vk < s) begin
      if (vk == ek) begin ck++; sk = ek; ek = box_edge(ck + 1); end
      return;
    end
    vk = 0; ck = 0; sk = 0; ek = box_edge(1);
    vj++;
    if (vj < s) begin
      if (vj == ej) begin cj++; sj = ej; ej = box_edge(cj + 1); end
      return;
    end
    vj = 0; cj = 0; sj = 0; ej = box_edge(1);
    vi++;
    if (vi < s) begin
      if (vi == ei) begin ci++; si = ei; ei = box_edge(ci + 1); end
      return;
    end
    vi = 0; ci = 0; si = 0; ei = box_edge(1);
  endtask

  // ---------------------------------------------------------------------
  // Rising edge: register writes, accepted items, accepted results
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n) begin
      if (cfg_we) apply_register(cfg_index, cfg_wdata);
      if (push && !full) begin
        accumulate_voxel(pending_voxels.pop_front());
        voxels_sent++;
        accepts++;
      end
      if (pop && !empty) begin
        if (expected_cells.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected cell %0d", got.cidx);
        end else begin
          cell_t e;
          e = expected_cells.pop_front();
          cells_checked++;
          if (got.done) frames_seen++;
          if (got !== e) begin
            errors++;
            if (errors <= 10)
              $display("mismatch cell exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                       e.cidx, e.tp_q, e.pe_q, e.te_q, e.done,
                       got.cidx, got.tp_q, got.pe_q, got.te_q, got.done);
          end
        end
      end
    end
  end

  // Long receiver hold-off, counted here in cycles
  always @(posedge clk) begin
    if (holdoff_req != holdoff_ack) begin
      holdoff_ack <= holdoff_req;
      holdoff_left <= 3000;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Falling edge: the driver offers the next pending item, the receiver decides pop
  always @(negedge clk) begin
    if (rst_n) begin
      if (!push || accepts != accepts_seen) begin
        accepts_seen <= accepts;
        // the item just taken has already left the queue
        if (pending_voxels.size() > 0 && $urandom_range(99) >= sender_idle) begin
          push <= 1'b1;
          drv_vox <= pending_voxels[0];
        end else begin
          push <= 1'b0;
        end
      end
      pop <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // All items accepted, all cells back, then let the tail of the pipe drain
  task automatic settle();
    while (pending_voxels.size() > 0 || expected_cells.size() > 0 || push)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_component();
    int unsigned r;
    r = $urandom_range(3);
    case (r)
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return 16'($urandom_range(8191) - 4096);  // around +-1.0
    endcase
  endfunction

  function automatic voxel_t random_voxel();
    voxel_t v;
    v.phi_a = pick_component(); v.phi_b = pick_component(); v.phi_c = pick_component();
    v.theta_a = pick_component(); v.theta_b = pick_component();
    v.theta_c = pick_component();
    return v;
  endfunction

  // Gains near the useful range, with the zero and all-ones extremes mixed in
  function automatic logic [31:0] pick_gain(logic [31:0] typical);
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      default: return $urandom_range(2 * typical);
    endcase
  endfunction

  int unsigned size_table [12][2] = '{
    '{1, 1}, '{2, 2}, '{3, 2}, '{4, 2}, '{5, 3}, '{6, 4},
    '{8, 3}, '{7, 1}, '{9, 5}, '{0, 0}, '{3, 127}, '{2, 1}
  };

  initial begin
    voxel_t v;
    int unsigned n_items;
    p_src = 11'd64; p_prv = 7'd64;
    p_gain_tp = '0; p_gain_pe = '0; p_gain_te = '0;
    restart_volume();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: side 64 to 64, so every voxel closes its own cell
    write_reg(vebdq_pkg::REG_GAIN_TP, 32'hffff_ffff);
    write_reg(vebdq_pkg::REG_GAIN_PE, 32'hffff_ffff);
    write_reg(vebdq_pkg::REG_GAIN_TE, 32'd22_000_000);
    write_reg(3'd5, 32'h1234_5678);        // unknown index: ignored
    write_reg(3'd7, 32'hffff_ffff);
    for (int n = 0; n < 8; n++) begin
      v = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h0001};
      if (n[0]) v = ~v;
      if (n[1]) v = '{16'h0000, 16'h0001, 16'hffff, 16'h1000, 16'hf000, 16'h0000};
      if (n[2]) v.phi_b = 16'h7fff;
      pending_voxels.push_back(v);
    end
    settle();

    // Saturating size writes, then zero triple-product and phi-energy gains on small boxes
    write_reg(vebdq_pkg::REG_SRC_SIDE, 32'h7ff);      // saturates to the largest side
    write_reg(vebdq_pkg::REG_PRV_SIDE, 32'h7f);
    write_reg(vebdq_pkg::REG_SRC_SIDE, 32'd4);
    write_reg(vebdq_pkg::REG_PRV_SIDE, 32'd2);
    write_reg(vebdq_pkg::REG_GAIN_TP, 32'd0);
    write_reg(vebdq_pkg::REG_GAIN_PE, 32'd0);
    for (int n = 0; n < 16; n++) pending_voxels.push_back(random_voxel());
    settle();

    // Random phases: sizes, gains and idling pattern change between phases
    for (int ph = 0; ph < 16; ph++) begin
      int unsigned t;
      t = (ph < 12) ? ph : $urandom_range(11);
      write_reg(vebdq_pkg::REG_SRC_SIDE, size_table[t][0]);
      write_reg(vebdq_pkg::REG_PRV_SIDE, size_table[t][1]);
      write_reg(vebdq_pkg::REG_GAIN_TP, pick_gain(32'd8_355_840));
      write_reg(vebdq_pkg::REG_GAIN_PE, pick_gain(32'd22_282_240));
      write_reg(vebdq_pkg::REG_GAIN_TE, pick_gain(32'd22_282_240));
      case (ph % 4)
        0: begin sender_idle = 0;  recv_stall = 0;  end
        1: begin sender_idle = 70; recv_stall = 0;  end
        2: begin sender_idle = 0;  recv_stall = 70; end
        default: begin sender_idle = 17; recv_stall = 17; end
      endcase
      n_items = $urandom_range(60, 110);
      for (int n = 0; n < n_items; n++) pending_voxels.push_back(random_voxel());
      // one phase with one-voxel boxes: stop the receiver long enough to back up
      if (t == 1 && holdoff_req == 0) begin
        sender_idle = 0;
        holdoff_req++;
      end
      settle();
    end

    $display("covered %0d voxels over several cube and preview sizes, %0d cells checked",
             voxels_sent, cells_checked);
    $display("%0d frame ends seen; idling, stalling and a long receiver hold-off",
             frames_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/vebdq_pkg.sv
rtl/vebdq_ram.sv
rtl/vebdq_front.sv
rtl/vebdq_back.sv
rtl/voxel_energy_box_downsample_quantize_unit.sv
tb/tb_voxel_energy_box_downsample_quantize_unit.sv
